/* src/lob_pkg.sv */
package lob_pkg;

  localparam int ID_BITS = 32;

  typedef enum logic [2:0] {
    ACT_LIMIT   = 3'd0,
    ACT_COUNTER = 3'd1,
    ACT_CLIENT  = 3'd2,
    ACT_BEST5   = 3'd3,
    ACT_FAK     = 3'd4,
    ACT_FOK     = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    STAT_FILLED    = 3'd0,
    STAT_RESTED    = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_REJECTED  = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    BOP_HOLD = 2'd0,
    BOP_POP  = 2'd1,
    BOP_DEC  = 2'd2,
    BOP_INS  = 2'd3
  } book_op_t;

  localparam logic [2:0] BEST_LEVELS = 3'd5;

endpackage

/* src/lob_cell.sv */
module lob_cell #(
  parameter int PRICE_BITS = 24,
  parameter int QTY_BITS   = 24
) (
  input  logic                          clk,
  input  lob_pkg::book_op_t             op,
  input  logic                          ask,
  input  logic                          head,
  input  logic                          occupied,
  input  logic                          left_keep,
  input  logic [lob_pkg::ID_BITS-1:0]   left_id,
  input  logic [PRICE_BITS-1:0]         left_price,
  input  logic [QTY_BITS-1:0]           left_qty,
  input  logic [lob_pkg::ID_BITS-1:0]   right_id,
  input  logic [PRICE_BITS-1:0]         right_price,
  input  logic [QTY_BITS-1:0]           right_qty,
  input  logic [lob_pkg::ID_BITS-1:0]   new_id,
  input  logic [PRICE_BITS-1:0]         new_price,
  input  logic [QTY_BITS-1:0]           new_qty,
  input  logic [QTY_BITS-1:0]           dec_qty,
  output logic [lob_pkg::ID_BITS-1:0]   id,
  output logic [PRICE_BITS-1:0]         price,
  output logic [QTY_BITS-1:0]           qty,
  output logic                          keep
);

  logic [lob_pkg::ID_BITS-1:0] id_next;
  logic [PRICE_BITS-1:0]       price_next;
  logic [QTY_BITS-1:0]         qty_next;

  // entries at an equal or better price stay ahead of a new one
  assign keep = occupied && (ask ? (price <= new_price) : (price >= new_price));

  always_comb begin
    id_next    = id;
    price_next = price;
    qty_next   = qty;
    unique case (op)
      lob_pkg::BOP_HOLD: ;
      lob_pkg::BOP_POP: begin
        id_next    = right_id;
        price_next = right_price;
        qty_next   = right_qty;
      end
      lob_pkg::BOP_DEC: begin
        if (head) qty_next = qty - dec_qty;
      end
      lob_pkg::BOP_INS: begin
        if (!keep) begin
          if (left_keep) begin
            id_next    = new_id;
            price_next = new_price;
            qty_next   = new_qty;
          end else begin
            id_next    = left_id;
            price_next = left_price;
            qty_next   = left_qty;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id    <= id_next;
    price <= price_next;
    qty   <= qty_next;
  end

endmodule

/* src/lob_book.sv */
module lob_book #(
  parameter int BOOK_DEPTH = 32,
  parameter int PRICE_BITS = 24,
  parameter int QTY_BITS   = 24,
  parameter int CNT_BITS   = 6,
  parameter int SUM_BITS   = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ask,
  input  lob_pkg::book_op_t           op,
  input  logic [lob_pkg::ID_BITS-1:0] new_id,
  input  logic [PRICE_BITS-1:0]       new_price,
  input  logic [QTY_BITS-1:0]         new_qty,
  input  logic [QTY_BITS-1:0]         dec_qty,
  output logic [lob_pkg::ID_BITS-1:0] head_id,
  output logic [PRICE_BITS-1:0]       head_price,
  output logic [QTY_BITS-1:0]         head_qty,
  output logic [CNT_BITS-1:0]         count,
  output logic [SUM_BITS-1:0]         sum
);

  logic [lob_pkg::ID_BITS-1:0] ids    [BOOK_DEPTH];
  logic [PRICE_BITS-1:0]       prices [BOOK_DEPTH];
  logic [QTY_BITS-1:0]         qtys   [BOOK_DEPTH];
  logic                        keeps  [BOOK_DEPTH];

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    logic [lob_pkg::ID_BITS-1:0] l_id, r_id;
    logic [PRICE_BITS-1:0]       l_price, r_price;
    logic [QTY_BITS-1:0]         l_qty, r_qty;
    logic                        l_keep;
    if (i == 0) begin : g_first
      assign l_id = new_id;
      assign l_price = new_price;
      assign l_qty = new_qty;
      assign l_keep = 1'b1;
    end else begin : g_mid
      assign l_id = ids[i-1];
      assign l_price = prices[i-1];
      assign l_qty = qtys[i-1];
      assign l_keep = keeps[i-1];
    end
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign r_id = ids[i];
      assign r_price = prices[i];
      assign r_qty = qtys[i];
    end else begin : g_inner
      assign r_id = ids[i+1];
      assign r_price = prices[i+1];
      assign r_qty = qtys[i+1];
    end
    lob_cell #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_cell (
      .clk(clk), .op(op), .ask(ask), .head(i == 0),
      .occupied(CNT_BITS'(i) < count),
      .left_keep(l_keep), .left_id(l_id), .left_price(l_price), .left_qty(l_qty),
      .right_id(r_id), .right_price(r_price), .right_qty(r_qty),
      .new_id(new_id), .new_price(new_price), .new_qty(new_qty), .dec_qty(dec_qty),
      .id(ids[i]), .price(prices[i]), .qty(qtys[i]), .keep(keeps[i])
    );
  end

  assign head_id    = ids[0];
  assign head_price = prices[0];
  assign head_qty   = qtys[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else begin
      unique case (op)
        lob_pkg::BOP_HOLD: ;
        lob_pkg::BOP_POP: begin
          count <= count - CNT_BITS'(1);
          sum   <= sum - SUM_BITS'(dec_qty);
        end
        lob_pkg::BOP_DEC: sum <= sum - SUM_BITS'(dec_qty);
        lob_pkg::BOP_INS: begin
          count <= count + CNT_BITS'(1);
          sum   <= sum + SUM_BITS'(new_qty);
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/limit_order_book_matcher.sv */
// Sequence: decode, then trades when matching, an end check, an insert when the remainder
// rests, then the status item; a reject goes from decode straight to the status item.
// One order at a time: a new order is taken only after its status item enters the output
// register; one trade per cycle off the head cell of the opposite book while the output is not stalled.
// Reset (rst, synchronous): books empty, totals and order number zero,
// floor 0 and ceiling all ones.
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = 32,
  parameter int PRICE_BITS = 24,
  parameter int QTY_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [PRICE_BITS-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  action,
  input  logic                        side,
  input  logic [PRICE_BITS-1:0]       limit_price,
  input  logic [QTY_BITS-1:0]         quantity,
  input  logic                        admit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lob_pkg::ID_BITS-1:0] buyer_id,
  output logic [lob_pkg::ID_BITS-1:0] seller_id,
  output logic [PRICE_BITS-1:0]       trade_price,
  output logic [QTY_BITS-1:0]         trade_qty,
  output logic                        trade_valid,
  output logic [2:0]                  status,
  output logic                        last
);

  localparam int CNT_BITS = $clog2(BOOK_DEPTH + 1);
  localparam int SUM_BITS = QTY_BITS + CNT_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_MATCH  = 5'b00100,
    ST_REST   = 5'b01000,
    ST_FINAL  = 5'b10000
  } state_t;

  state_t state;
  logic [PRICE_BITS-1:0]       price_floor, price_ceiling;
  logic [lob_pkg::ID_BITS-1:0] next_id, oid;
  logic [2:0]                  act;
  logic                        sd, adm, limited, lvl_on, rest_after;
  logic [PRICE_BITS-1:0]       lim, lastp;
  logic [QTY_BITS-1:0]         vol;
  logic [2:0]                  levels;
  lob_pkg::status_t            fin;

  lob_pkg::book_op_t           bid_op, ask_op;
  logic [lob_pkg::ID_BITS-1:0] bid_hid, ask_hid;
  logic [PRICE_BITS-1:0]       bid_hp, ask_hp;
  logic [QTY_BITS-1:0]         bid_hq, ask_hq, dec_qty;
  logic [CNT_BITS-1:0]         bid_cnt, ask_cnt;
  logic [SUM_BITS-1:0]         bid_sum, ask_sum;

  lob_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
             .CNT_BITS(CNT_BITS), .SUM_BITS(SUM_BITS)) u_bid (
    .clk(clk), .rst(rst), .ask(1'b0), .op(bid_op), .new_id(oid), .new_price(lim),
    .new_qty(vol), .dec_qty(dec_qty), .head_id(bid_hid), .head_price(bid_hp),
    .head_qty(bid_hq), .count(bid_cnt), .sum(bid_sum)
  );

  lob_book #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
             .CNT_BITS(CNT_BITS), .SUM_BITS(SUM_BITS)) u_ask (
    .clk(clk), .rst(rst), .ask(1'b1), .op(ask_op), .new_id(oid), .new_price(lim),
    .new_qty(vol), .dec_qty(dec_qty), .head_id(ask_hid), .head_price(ask_hp),
    .head_qty(ask_hq), .count(ask_cnt), .sum(ask_sum)
  );

  // opposite and own book views
  logic [lob_pkg::ID_BITS-1:0] opp_hid;
  logic [PRICE_BITS-1:0]       opp_hp, own_hp, eff_price;
  logic [QTY_BITS-1:0]         opp_hq;
  logic                        opp_nz, own_nz, own_full, slot_free;
  logic [SUM_BITS-1:0]         opp_sum;
  logic                        cross_fail, new_level, lvl_fail, go, in_range;
  logic                        emit;

  assign opp_hid  = sd ? bid_hid : ask_hid;
  assign opp_hp   = sd ? bid_hp : ask_hp;
  assign opp_hq   = sd ? bid_hq : ask_hq;
  assign opp_sum  = sd ? bid_sum : ask_sum;
  assign opp_nz   = sd ? (bid_cnt != '0) : (ask_cnt != '0);
  assign own_hp   = sd ? ask_hp : bid_hp;
  assign own_nz   = sd ? (ask_cnt != '0) : (bid_cnt != '0);
  assign own_full = sd ? (ask_cnt == CNT_BITS'(BOOK_DEPTH)) : (bid_cnt == CNT_BITS'(BOOK_DEPTH));

  assign eff_price  = (act == lob_pkg::ACT_COUNTER) ? opp_hp : lim;
  assign in_range   = (eff_price >= price_floor) && (eff_price <= price_ceiling);
  assign cross_fail = limited && (sd ? (opp_hp < lim) : (opp_hp > lim));
  assign new_level  = (levels == 3'd0) || (opp_hp != lastp);
  assign lvl_fail   = lvl_on && new_level && (levels >= lob_pkg::BEST_LEVELS);
  assign go         = opp_nz && (vol != '0) && !cross_fail && !lvl_fail;
  assign dec_qty    = (opp_hq < vol) ? opp_hq : vol;
  assign slot_free  = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);
  // a trade or the status item enters the output register
  assign emit       = slot_free && ((state == ST_MATCH && go) || state == ST_FINAL);

  lob_pkg::book_op_t opp_op, own_op;
  always_comb begin
    opp_op = lob_pkg::BOP_HOLD;
    own_op = lob_pkg::BOP_HOLD;
    if (state == ST_MATCH && go && slot_free)
      opp_op = (opp_hq == dec_qty) ? lob_pkg::BOP_POP : lob_pkg::BOP_DEC;
    if (state == ST_REST && !own_full)
      own_op = lob_pkg::BOP_INS;
    bid_op = sd ? opp_op : own_op;
    ask_op = sd ? own_op : opp_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      next_id       <= '0;
      price_floor   <= '0;
      price_ceiling <= '1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (lob_pkg::reg_index_t'(cfg_index))
          lob_pkg::REG_FLOOR:   price_floor <= cfg_data;
          lob_pkg::REG_CEILING: price_ceiling <= cfg_data;
          default: ;
        endcase
      end
      out_valid <= emit || (out_valid && out_stall);

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act     <= action;
            sd      <= side;
            adm     <= admit;
            lim     <= limit_price;
            vol     <= quantity;
            oid     <= next_id + 32'd1;
            next_id <= next_id + 32'd1;
            levels  <= 3'd0;
            state   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          fin        <= lob_pkg::STAT_REJECTED;
          limited    <= 1'b0;
          lvl_on     <= 1'b0;
          rest_after <= 1'b0;
          state      <= ST_FINAL;
          if (adm && act <= 3'd5 && vol != '0) begin
            priority case (act)
              lob_pkg::ACT_LIMIT, lob_pkg::ACT_COUNTER: begin
                if ((act == lob_pkg::ACT_LIMIT || opp_nz) && in_range) begin
                  lim        <= eff_price;
                  limited    <= 1'b1;
                  rest_after <= 1'b1;
                  state      <= ST_MATCH;
                end
              end
              lob_pkg::ACT_CLIENT: begin
                if (own_nz) begin
                  lim   <= own_hp;
                  state <= ST_REST;
                end
              end
              lob_pkg::ACT_BEST5: begin
                lvl_on <= 1'b1;
                state  <= ST_MATCH;
              end
              lob_pkg::ACT_FAK: state <= ST_MATCH;
              default: begin
                if (opp_sum >= SUM_BITS'(vol)) state <= ST_MATCH;
              end
            endcase
          end
        end
        ST_MATCH: begin
          if (go) begin
            if (slot_free) begin
              buyer_id    <= sd ? opp_hid : oid;
              seller_id   <= sd ? oid : opp_hid;
              trade_price <= opp_hp;
              trade_qty   <= dec_qty;
              trade_valid <= 1'b1;
              status      <= lob_pkg::STAT_FILLED;
              last        <= 1'b0;
              vol         <= vol - dec_qty;
              lastp       <= opp_hp;
              if (new_level && lvl_on) levels <= levels + 3'd1;
              else if (levels == 3'd0) levels <= 3'd1;
            end
          end else if (rest_after && vol != '0) begin
            state <= ST_REST;
          end else begin
            fin   <= (vol != '0) ? lob_pkg::STAT_CANCELLED : lob_pkg::STAT_FILLED;
            state <= ST_FINAL;
          end
        end
        ST_REST: begin
          fin   <= own_full ? lob_pkg::STAT_FULL : lob_pkg::STAT_RESTED;
          state <= ST_FINAL;
        end
        ST_FINAL: begin
          if (slot_free) begin
            buyer_id    <= '0;
            seller_id   <= '0;
            trade_price <= '0;
            trade_qty   <= '0;
            trade_valid <= 1'b0;
            status      <= fin;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/lob_checker.sv */
module lob_checker #(
  parameter int PRICE_BITS = 24,
  parameter int QTY_BITS   = 24
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lob_pkg::ID_BITS-1:0] buyer_id,
  input logic [lob_pkg::ID_BITS-1:0] seller_id,
  input logic [QTY_BITS-1:0]         trade_qty,
  input logic                        trade_valid,
  input logic [2:0]                  status,
  input logic                        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_trade_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && trade_valid |-> !last && status == 3'd0)
    else $error("trade item carries status");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trade_valid |-> last && buyer_id == '0 && seller_id == '0 &&
    trade_qty == '0)
    else $error("bad status item");

  a_one_order: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second order taken before the first finished");

endmodule

bind limit_order_book_matcher lob_checker #(
  .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)
) u_lob_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .buyer_id(buyer_id),
  .seller_id(seller_id), .trade_qty(trade_qty), .trade_valid(trade_valid),
  .status(status), .last(last)
);
